// ----- design/nrc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-row classifier package
// Shared widths, register map, configuration, table row and the command and
// status structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package nrc_pkg;

  localparam int TABLE_ROWS = 256;
  localparam int ROW_W      = $clog2(TABLE_ROWS);
  localparam int ROWS_CNT_W = $clog2(TABLE_ROWS + 1);
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int CLASS_W    = 16;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int DIST_W     = COORD_W + 2;

  localparam int DATA_W     = 32;
  localparam int NUM_REGS   = 7;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int ADDR_W     = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_OFF_G = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_OFF_B = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_OFF_T = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_RS_G  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_RS_B  = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_RS_T  = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_ROWS  = REG_IDX_W'(6);

  localparam logic [COORD_W-1:0] RECIP_ONE = COORD_W'(1 << FRAC_BITS);

  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  typedef enum logic [1:0] {
    CH_GREEN = 2'd0,
    CH_BLUE  = 2'd1,
    CH_TEMP  = 2'd2
  } ch_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] offset_green;
    logic signed [COORD_W-1:0] offset_blue;
    logic signed [COORD_W-1:0] offset_temp;
    logic [COORD_W-1:0]        recip_scale_green;
    logic [COORD_W-1:0]        recip_scale_blue;
    logic [COORD_W-1:0]        recip_scale_temp;
    logic [ROWS_CNT_W-1:0]     rows_in_use;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] green;
    logic signed [COORD_W-1:0] blue;
    logic signed [COORD_W-1:0] temp;
    logic signed [CLASS_W-1:0] class_a;
    logic signed [CLASS_W-1:0] class_b;
    logic signed [CLASS_W-1:0] class_c;
  } row_t;

  typedef struct packed {
    logic             in_ready;
    ch_t              ch;
    logic             sub_en;
    logic             mul_en;
    logic             rnd_en;
    logic             wr_en;
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             in_valid;
    logic             func;
    logic             missing;
    logic [ROW_W-1:0] last_row;
    logic             pipe_busy;
    logic             out_free;
  } dp_status_t;

endpackage : nrc_pkg
`default_nettype wire

// ----- design/nrc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-row classifier channel interfaces
// Valid/ready channels for input items and for classification results.
// ----------------------------------------------------------------------------
interface nrc_item_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [nrc_pkg::ROW_W-1:0]           row_index;
  logic signed [nrc_pkg::COORD_W-1:0]  coord_green;
  logic signed [nrc_pkg::COORD_W-1:0]  coord_blue;
  logic signed [nrc_pkg::COORD_W-1:0]  coord_temp;
  logic signed [nrc_pkg::COORD_W-1:0]  temp_reference;
  logic                                temp_present;
  logic                                green_missing;
  logic                                blue_missing;
  logic signed [nrc_pkg::CLASS_W-1:0]  class_a_in;
  logic signed [nrc_pkg::CLASS_W-1:0]  class_b_in;
  logic signed [nrc_pkg::CLASS_W-1:0]  class_c_in;

  modport source (
    output valid, func, row_index, coord_green, coord_blue, coord_temp,
           temp_reference, temp_present, green_missing, blue_missing,
           class_a_in, class_b_in, class_c_in,
    input  ready
  );
  modport sink (
    input  valid, func, row_index, coord_green, coord_blue, coord_temp,
           temp_reference, temp_present, green_missing, blue_missing,
           class_a_in, class_b_in, class_c_in,
    output ready
  );
endinterface : nrc_item_if

interface nrc_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [nrc_pkg::CLASS_W-1:0]  class_a_out;
  logic signed [nrc_pkg::CLASS_W-1:0]  class_b_out;
  logic signed [nrc_pkg::CLASS_W-1:0]  class_c_out;
  logic [nrc_pkg::ROW_W-1:0]           best_row;
  logic                                pixel_missing;

  modport source (
    output valid, class_a_out, class_b_out, class_c_out, best_row, pixel_missing,
    input  ready
  );
  modport sink (
    input  valid, class_a_out, class_b_out, class_c_out, best_row, pixel_missing,
    output ready
  );
endinterface : nrc_result_if
`default_nettype wire

// ----- design/nearest_row_l1_classifier.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-row L1 classifier
// Classifies pixels by the least sum of absolute differences to a row table.
// ----------------------------------------------------------------------------
// A load item writes one table row and then returns the block to idle. A
// classify item with a missing radiance goes from decode straight to the
// result hand-off. Any other classify item normalizes the three values in
// turn (subtract, multiply, round) on one shared 32x32 multiplier, scans the
// table's single read port one row per cycle, and then drains the distance
// pipeline. The next item is accepted while a result waits in the output
// register. The table is not cleared at reset; rows must be loaded before
// they are searched.
// ----------------------------------------------------------------------------
module nearest_row_l1_classifier (
  input  wire logic                        clk,
  input  wire logic                        rst,
  nrc_item_if.sink                         item,
  nrc_result_if.source                     result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nrc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [nrc_pkg::DATA_W-1:0]  pwdata,
  output logic      [nrc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import nrc_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  nrc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nrc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  nrc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status),
    .item   (item),
    .result (result)
  );

endmodule : nearest_row_l1_classifier
`default_nettype wire

// ----- design/nrc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : nrc_ram
`default_nettype wire

// ----- design/nrc_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-row classifier configuration registers
// APB register file holding offsets, reciprocal scales and the row count.
// ----------------------------------------------------------------------------
module nrc_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nrc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [nrc_pkg::DATA_W-1:0]  pwdata,
  output logic      [nrc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output nrc_pkg::cfg_t                    cfg
);
  import nrc_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_green      <= '0;
      cfg.offset_blue       <= '0;
      cfg.offset_temp       <= '0;
      cfg.recip_scale_green <= RECIP_ONE;
      cfg.recip_scale_blue  <= RECIP_ONE;
      cfg.recip_scale_temp  <= RECIP_ONE;
      cfg.rows_in_use       <= ROWS_CNT_W'(1);
    end else if (wr) begin
      unique case (idx)
        REG_OFF_G: cfg.offset_green      <= pwdata[COORD_W-1:0];
        REG_OFF_B: cfg.offset_blue       <= pwdata[COORD_W-1:0];
        REG_OFF_T: cfg.offset_temp       <= pwdata[COORD_W-1:0];
        REG_RS_G:  cfg.recip_scale_green <= pwdata[COORD_W-1:0];
        REG_RS_B:  cfg.recip_scale_blue  <= pwdata[COORD_W-1:0];
        REG_RS_T:  cfg.recip_scale_temp  <= pwdata[COORD_W-1:0];
        REG_ROWS:  cfg.rows_in_use       <= pwdata[ROWS_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OFF_G: prdata = DATA_W'(cfg.offset_green);
      REG_OFF_B: prdata = DATA_W'(cfg.offset_blue);
      REG_OFF_T: prdata = DATA_W'(cfg.offset_temp);
      REG_RS_G:  prdata = DATA_W'(cfg.recip_scale_green);
      REG_RS_B:  prdata = DATA_W'(cfg.recip_scale_blue);
      REG_RS_T:  prdata = DATA_W'(cfg.recip_scale_temp);
      REG_ROWS:  prdata = DATA_W'(cfg.rows_in_use);
      default:   prdata = '0;
    endcase
  end

endmodule : nrc_regs
`default_nettype wire

// ----- design/nrc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-row classifier controller
// Sequences row loads, normalization, the table scan and result hand-off.
// ----------------------------------------------------------------------------
module nrc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  nrc_pkg::dp_status_t      status,
  output nrc_pkg::ctrl_cmd_t       cmd
);
  import nrc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_SUB    = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_RND    = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_DRAIN  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t           state, state_next;
  ch_t              ch, ch_next;
  logic [ROW_W-1:0] row, row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= CH_GREEN;
      row   <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      row   <= row_next;
    end
  end

  always_comb begin
    state_next   = state;
    ch_next      = ch;
    row_next     = row;
    cmd          = '0;
    cmd.ch       = ch;
    cmd.rd_addr  = row;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (status.func == FUNC_LOAD) begin
          cmd.wr_en  = 1'b1;
          state_next = S_IDLE;
        end else if (status.missing) begin
          state_next = S_DONE;
        end else begin
          ch_next    = CH_GREEN;
          state_next = S_SUB;
        end
      end
      S_SUB: begin
        cmd.sub_en = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd_en = 1'b1;
        if (ch == CH_TEMP) begin
          row_next   = '0;
          state_next = S_SCAN;
        end else begin
          ch_next    = (ch == CH_GREEN) ? CH_BLUE : CH_TEMP;
          state_next = S_SUB;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (row == status.last_row) begin
          state_next = S_DRAIN;
        end else begin
          row_next = row + ROW_W'(1);
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule : nrc_ctrl
`default_nettype wire

// ----- design/nrc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-row classifier datapath
// Item capture, shared normalization multiplier, row table, distance pipeline,
// best-row tracking and the result register.
// ----------------------------------------------------------------------------
module nrc_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  nrc_pkg::cfg_t      cfg,
  input  nrc_pkg::ctrl_cmd_t cmd,
  output nrc_pkg::dp_status_t status,
  nrc_item_if.sink           item,
  nrc_result_if.source       result
);
  import nrc_pkg::*;

  localparam logic signed [COORD_W-1:0] TEMP_FLOOR = COORD_W'(-(2 <<< FRAC_BITS));
  localparam logic [PROD_W-1:0]         RND_HALF   = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [COORD_W-1:0] SAT_MAX    = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] SAT_MIN    = {1'b1, {(COORD_W-1){1'b0}}};

  function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] nd;
    d  = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    nd = -d;
    return d[COORD_W] ? nd[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

  logic                      take;
  logic                      cap_func;
  logic [ROW_W-1:0]          cap_row;
  logic signed [COORD_W-1:0] cap_green, cap_blue, cap_temp, cap_traw;
  logic                      cap_missing;
  logic signed [CLASS_W-1:0] cap_class_a, cap_class_b, cap_class_c;

  logic signed [COORD_W-1:0] sel_raw, sel_off;
  logic [COORD_W-1:0]        sel_recip;
  logic [COORD_W:0]          diff, diff_neg;
  logic [COORD_W-1:0]        mag;
  logic                      neg;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         q;
  logic                      q_big;
  logic signed [COORD_W-1:0] q_sat;
  logic signed [COORD_W-1:0] norm_g, norm_b, norm_t;

  row_t                      wr_row;
  row_t                      rd_row;

  logic                      p1_v, p2_v, p3_v;
  logic [ROW_W-1:0]          p1_row, p2_row, p3_row;
  logic [COORD_W-1:0]        ad_g, ad_b, ad_t;
  logic signed [CLASS_W-1:0] p2_class_a, p2_class_b, p2_class_c;
  logic signed [CLASS_W-1:0] p3_class_a, p3_class_b, p3_class_c;
  logic [DIST_W-1:0]         row_dist;

  logic [DIST_W-1:0]         best_dist;
  logic [ROW_W-1:0]          best_row;
  logic signed [CLASS_W-1:0] best_class_a, best_class_b, best_class_c;

  logic                      out_valid;

  // Item capture.
  assign item.ready = cmd.in_ready;
  assign take       = item.valid && cmd.in_ready;

  always_ff @(posedge clk) begin
    if (take) begin
      cap_func    <= item.func;
      cap_row     <= item.row_index;
      cap_green   <= item.coord_green;
      cap_blue    <= item.coord_blue;
      cap_temp    <= item.coord_temp;
      cap_traw    <= (item.temp_present && (item.coord_temp > TEMP_FLOOR))
                     ? item.coord_temp : item.temp_reference;
      cap_missing <= item.green_missing || item.blue_missing;
      cap_class_a <= item.class_a_in;
      cap_class_b <= item.class_b_in;
      cap_class_c <= item.class_c_in;
    end
  end

  // Normalization, one channel at a time: subtract, multiply, round.
  always_comb begin
    unique case (cmd.ch)
      CH_GREEN: begin
        sel_raw   = cap_green;
        sel_off   = cfg.offset_green;
        sel_recip = cfg.recip_scale_green;
      end
      CH_BLUE: begin
        sel_raw   = cap_blue;
        sel_off   = cfg.offset_blue;
        sel_recip = cfg.recip_scale_blue;
      end
      default: begin
        sel_raw   = cap_traw;
        sel_off   = cfg.offset_temp;
        sel_recip = cfg.recip_scale_temp;
      end
    endcase
  end

  assign diff     = {sel_raw[COORD_W-1], sel_raw} - {sel_off[COORD_W-1], sel_off};
  assign diff_neg = -diff;

  always_ff @(posedge clk) begin
    if (cmd.sub_en) begin
      neg <= diff[COORD_W];
      mag <= diff[COORD_W] ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];
    end
    if (cmd.mul_en) begin
      prod <= PROD_W'(mag) * PROD_W'(sel_recip);
    end
  end

  assign q     = (prod + RND_HALF) >> FRAC_BITS;
  assign q_big = |q[PROD_W-1:COORD_W-1];

  always_comb begin
    if (neg) begin
      q_sat = q_big ? SAT_MIN : -$signed(q[COORD_W-1:0]);
    end else begin
      q_sat = q_big ? SAT_MAX : $signed(q[COORD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rnd_en) begin
      unique case (cmd.ch)
        CH_GREEN: norm_g <= q_sat;
        CH_BLUE:  norm_b <= q_sat;
        default:  norm_t <= q_sat;
      endcase
    end
  end

  // Row table.
  assign wr_row.green   = cap_green;
  assign wr_row.blue    = cap_blue;
  assign wr_row.temp    = cap_temp;
  assign wr_row.class_a = cap_class_a;
  assign wr_row.class_b = cap_class_b;
  assign wr_row.class_c = cap_class_c;

  nrc_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (TABLE_ROWS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cap_row),
    .wdata (wr_row),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rd_row)
  );

  // Distance pipeline: table read, absolute differences, sum, compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else begin
      p1_v <= cmd.rd_en;
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    p1_row     <= cmd.rd_addr;
    p2_row     <= p1_row;
    p3_row     <= p2_row;
    ad_g       <= abs_diff(norm_g, rd_row.green);
    ad_b       <= abs_diff(norm_b, rd_row.blue);
    ad_t       <= abs_diff(norm_t, rd_row.temp);
    p2_class_a <= rd_row.class_a;
    p2_class_b <= rd_row.class_b;
    p2_class_c <= rd_row.class_c;
    row_dist   <= DIST_W'(ad_g) + DIST_W'(ad_b) + DIST_W'(ad_t);
    p3_class_a <= p2_class_a;
    p3_class_b <= p2_class_b;
    p3_class_c <= p2_class_c;
  end

  // Row zero always seeds the search; later rows win only when strictly closer.
  always_ff @(posedge clk) begin
    if (p3_v && ((p3_row == '0) || (row_dist < best_dist))) begin
      best_dist    <= row_dist;
      best_row     <= p3_row;
      best_class_a <= p3_class_a;
      best_class_b <= p3_class_b;
      best_class_c <= p3_class_c;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.pixel_missing <= cap_missing;
      result.class_a_out   <= cap_missing ? '0 : best_class_a;
      result.class_b_out   <= cap_missing ? '0 : best_class_b;
      result.class_c_out   <= cap_missing ? '0 : best_class_c;
      result.best_row      <= cap_missing ? '0 : best_row;
    end
  end

  assign result.valid = out_valid;

  // Status to the controller.
  always_comb begin
    status.in_valid  = item.valid;
    status.func      = cap_func;
    status.missing   = cap_missing;
    status.pipe_busy = p1_v || p2_v || p3_v;
    status.out_free  = !out_valid || result.ready;
    priority if (cfg.rows_in_use == '0) begin
      status.last_row = '0;
    end else if (cfg.rows_in_use > ROWS_CNT_W'(TABLE_ROWS)) begin
      status.last_row = ROW_W'(TABLE_ROWS - 1);
    end else begin
      status.last_row = ROW_W'(cfg.rows_in_use - ROWS_CNT_W'(1));
    end
  end

endmodule : nrc_dp
`default_nettype wire
